[rtl/udrb_pkg.sv]
// ----------------------------------------------------------------------------
// udrb_pkg
// Shared types and constants for the UART dual ring buffer.
// ----------------------------------------------------------------------------
package udrb_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 7;
    localparam int KIND_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT    = 2'd0,
        KIND_TXDONE = 2'd1,
        KIND_RECV   = 2'd2,
        KIND_GET    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

endpackage

[rtl/udrb_ram.sv]
// ----------------------------------------------------------------------------
// udrb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module udrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/udrb_ring.sv]
// ----------------------------------------------------------------------------
// udrb_ring
// One ring buffer: write/read pointers, fill count and the backing RAM.
// ----------------------------------------------------------------------------
module udrb_ring #(
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  udrb_pkg::ring_cmd_t              cmd,
    input  logic [udrb_pkg::BYTE_W-1:0]      wdata,
    output logic [udrb_pkg::BYTE_W-1:0]      rdata,
    output logic [$clog2(DEPTH+1)-1:0]       fill,
    output udrb_pkg::ring_stat_t             stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (cmd.push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end else if (cmd.pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    udrb_ram #(
        .WIDTH (udrb_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (wr_ptr_reg),
        .wdata (wdata),
        .re    (cmd.pop),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    assign fill       = fill_reg;
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FW'(DEPTH));

endmodule

[rtl/uart_dual_ring_buffer.sv]
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// Transmit and receive ring buffers in front of a UART.
// ----------------------------------------------------------------------------
// Each beat carries one event: put a byte to send, transmit done, byte
// received, or get a received byte. Every beat gives exactly one result beat.
// An item is handled in S_IDLE, where the accept updates the pointers and issues
// the buffer read, then in S_WORK, which captures the registered RAM read data
// into the output register; the registered read of the buffer RAMs sets this.
// A new item is taken while the previous result waits, as long as that result
// is taken in the same cycle. Levels report the fill count masked to 7 bits.
// ----------------------------------------------------------------------------
module uart_dual_ring_buffer #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [udrb_pkg::KIND_W-1:0]       s_kind,
    input  logic [udrb_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic                              s_tx_idle,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_send_valid,
    output logic [udrb_pkg::BYTE_W-1:0]       m_send_byte,
    output logic                              m_read_valid,
    output logic [udrb_pkg::BYTE_W-1:0]       m_read_byte,
    output logic                              m_dropped,
    output logic [udrb_pkg::LEVEL_W-1:0]      m_tx_level,
    output logic [udrb_pkg::LEVEL_W-1:0]      m_rx_level
);

    udrb_pkg::state_t     state_reg, state_next;
    udrb_pkg::ring_cmd_t  tx_cmd, rx_cmd;
    udrb_pkg::ring_stat_t tx_stat, rx_stat;

    logic [udrb_pkg::BYTE_W-1:0]    tx_rdata, rx_rdata;
    logic [$clog2(TX_DEPTH+1)-1:0]  tx_fill;
    logic [$clog2(RX_DEPTH+1)-1:0]  rx_fill;

    logic                           accept;
    logic                           direct_next, send_pop_next, read_pop_next, drop_next;
    logic                           direct_reg, send_pop_reg, read_pop_reg, drop_reg;
    logic [udrb_pkg::BYTE_W-1:0]    byte_reg;

    logic                           m_valid_reg, m_send_valid_reg, m_read_valid_reg;
    logic                           m_dropped_reg;
    logic [udrb_pkg::BYTE_W-1:0]    m_send_byte_reg, m_read_byte_reg;
    logic [udrb_pkg::LEVEL_W-1:0]   m_tx_level_reg, m_rx_level_reg;

    assign s_ready = (state_reg == udrb_pkg::S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        direct_next   = 1'b0;
        send_pop_next = 1'b0;
        read_pop_next = 1'b0;
        drop_next     = 1'b0;
        tx_cmd        = '0;
        rx_cmd        = '0;
        unique case (udrb_pkg::kind_t'(s_kind))
            udrb_pkg::KIND_PUT: begin
                direct_next = s_tx_idle && tx_stat.empty;
                drop_next   = !direct_next && tx_stat.full;
                tx_cmd.push = accept && !direct_next && !tx_stat.full;
            end
            udrb_pkg::KIND_TXDONE: begin
                send_pop_next = !tx_stat.empty;
                tx_cmd.pop    = accept && send_pop_next;
            end
            udrb_pkg::KIND_RECV: begin
                drop_next   = rx_stat.full;
                rx_cmd.push = accept && !rx_stat.full;
            end
            udrb_pkg::KIND_GET: begin
                read_pop_next = !rx_stat.empty;
                rx_cmd.pop    = accept && read_pop_next;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            udrb_pkg::S_IDLE: if (accept) state_next = udrb_pkg::S_WORK;
            udrb_pkg::S_WORK: state_next = udrb_pkg::S_IDLE;
            default:          state_next = udrb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= udrb_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            direct_reg   <= direct_next;
            send_pop_reg <= send_pop_next;
            read_pop_reg <= read_pop_next;
            drop_reg     <= drop_next;
            byte_reg     <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == udrb_pkg::S_WORK) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == udrb_pkg::S_WORK) begin
            m_send_valid_reg <= direct_reg || send_pop_reg;
            m_send_byte_reg  <= direct_reg   ? byte_reg :
                                send_pop_reg ? tx_rdata : '0;
            m_read_valid_reg <= read_pop_reg;
            m_read_byte_reg  <= read_pop_reg ? rx_rdata : '0;
            m_dropped_reg    <= drop_reg;
            m_tx_level_reg   <= udrb_pkg::LEVEL_W'(tx_fill);
            m_rx_level_reg   <= udrb_pkg::LEVEL_W'(rx_fill);
        end
    end

    udrb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tx_cmd),
        .wdata   (s_data_byte),
        .rdata   (tx_rdata),
        .fill    (tx_fill),
        .stat    (tx_stat)
    );

    udrb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (rx_cmd),
        .wdata   (s_data_byte),
        .rdata   (rx_rdata),
        .fill    (rx_fill),
        .stat    (rx_stat)
    );

    assign m_valid      = m_valid_reg;
    assign m_send_valid = m_send_valid_reg;
    assign m_send_byte  = m_send_byte_reg;
    assign m_read_valid = m_read_valid_reg;
    assign m_read_byte  = m_read_byte_reg;
    assign m_dropped    = m_dropped_reg;
    assign m_tx_level   = m_tx_level_reg;
    assign m_rx_level   = m_rx_level_reg;

endmodule

[rtl/udrb_checker.sv]
// ----------------------------------------------------------------------------
// udrb_checker
// Port-level checks for the UART dual ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module udrb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_send_valid,
    input logic [udrb_pkg::BYTE_W-1:0]   m_send_byte,
    input logic                          m_read_valid,
    input logic [udrb_pkg::BYTE_W-1:0]   m_read_byte,
    input logic                          m_dropped
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_send_byte) && $stable(m_read_byte))
        else $error("result beat changed while stalled");

    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("accepted beat gave no result");

    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_send_valid, m_read_valid, m_dropped}) <= 1)
        else $error("result beat reports more than one action");

    a_zero_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_send_valid || m_send_byte == '0) && (m_read_valid || m_read_byte == '0))
        else $error("byte nonzero without its valid flag");

endmodule

bind uart_dual_ring_buffer udrb_checker u_udrb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_send_valid (m_send_valid),
    .m_send_byte  (m_send_byte),
    .m_read_valid (m_read_valid),
    .m_read_byte  (m_read_byte),
    .m_dropped    (m_dropped)
);
